// ----- design/tdps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the timer divider pair search block.
// No dependencies; imported by every module of the block.
package tdps_pkg;

   localparam int unsigned DATA_W              = 32;
   localparam int unsigned PRESCALER_W         = 10;
   localparam int unsigned RELOAD_W            = 16;
   localparam int unsigned REQ_TDATA_W         = 32;
   localparam int unsigned RSP_FIELDS_W        = PRESCALER_W + RELOAD_W + DATA_W;
   localparam int unsigned RSP_TDATA_W         = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int unsigned RSP_PAD_W           = RSP_TDATA_W - RSP_FIELDS_W;
   localparam int unsigned DIV_CNT_W           = $clog2(DATA_W);

   localparam int unsigned PRESCALER_LIMIT_DEF = 1024;
   localparam logic [DATA_W:0]   RELOAD_LIMIT      = 33'd65536;
   localparam logic [DATA_W-1:0] TIMER_CLOCK_RESET = 32'd84000000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_IDEAL_GO,
      ST_IDEAL_WAIT,
      ST_RP1_GO,
      ST_RP1_WAIT,
      ST_MUL,
      ST_FREQ_GO,
      ST_FREQ_WAIT,
      ST_ERR,
      ST_CMP,
      ST_NEXT,
      ST_FINISH
   } search_state_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- design/tdps_div.sv -----
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tdps_pkg for the request and response structs.
module tdps_div (
   input  logic                      clock,
   input  logic                      reset,
   input  tdps_pkg::div_req_type     div_req,
   output tdps_pkg::div_rsp_type     div_rsp
);
   import tdps_pkg::*;

   logic [DATA_W-1:0]    dq_ff, dq_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DATA_W:0]      shifted;
   logic [DATA_W:0]      diff;
   logic                 ge;

   always_comb begin
      shifted = {rem_ff, dq_ff[DATA_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      ge      = (shifted >= {1'b0, dsr_ff});
   end

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         dq_in   = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one dividend bit into the partial remainder, restore on borrow
         rem_in = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
         dq_in  = {dq_ff[DATA_W-2:0], ge};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dq_ff;

endmodule

// ----- design/timer_divider_pair_search_top.sv -----
`timescale 1ns / 1ps
// Top level of the timer divider pair search: control sequencer, serial multiplier.
// Depends on tdps_pkg and the shared divider tdps_div.
//
// Usage:
//  - csr_valid/csr_ready/csr_data writes the timer input clock in hertz. Write it
//    only while no search is in flight. Reset loads 84 MHz.
//  - A beat on req_* carries the target update frequency. One search runs at a time;
//    req_tready is high only while the sequencer is idle.
//  - A beat on rsp_* carries prescaler, reload and the resulting frequency; tuser
//    flags that no prescaler gave a reload in range (prescaler and reload are then
//    zero and the frequency is the timer clock itself).
//  - Sequence: one division for the ideal ratio, then for each prescaler tried two
//    divisions on the one shared radix-2 divider, a shift-add multiply and the error,
//    compare and advance steps, or the ratio division alone when the reload is out of
//    range, for up to PRESCALER_LIMIT prescalers (1024 by default). An exact match, or
//    a reload ratio of zero, ends it early.
//  - The result sits in an output register; a new request is taken while it waits.
//    If the receiver stalls, a finished search holds until the register frees up.
//  - Reset clears the sequencer and drops any pending result.
module timer_divider_pair_search_top #(
   parameter int unsigned PRESCALER_LIMIT = tdps_pkg::PRESCALER_LIMIT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tdps_pkg::DATA_W-1:0]           csr_data,      // timer_clock
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [tdps_pkg::REQ_TDATA_W-1:0]      req_tdata,     // [31:0] target_freq
   // response stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tdps_pkg::RSP_TDATA_W-1:0]      rsp_tdata,     // [9:0] prescaler,
                                                                // [25:10] reload,
                                                                // [57:26] actual_freq
   output logic                                  rsp_tuser      // no_fit
);
   import tdps_pkg::*;

   // width of prescaler plus one, which runs 1..PRESCALER_LIMIT
   localparam int unsigned P1W = $clog2(PRESCALER_LIMIT + 1);

   search_state_type state_ff, state_in;

   logic [DATA_W-1:0] clk_ff, clk_in;
   logic [DATA_W-1:0] tgt_ff, tgt_in;
   logic [DATA_W-1:0] ideal_ff, ideal_in;
   logic [P1W-1:0]    pp1_ff, pp1_in;
   logic [DATA_W-1:0] rp1_ff, rp1_in;
   logic [DATA_W-1:0] mcand_ff, mcand_in;
   logic [P1W-1:0]    mplier_ff, mplier_in;
   logic [DATA_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] freq_ff, freq_in;
   logic [DATA_W-1:0] err_ff, err_in;
   logic              found_ff, found_in;
   logic [DATA_W-1:0] best_err_ff, best_err_in;
   logic [P1W-1:0]    best_pp1_ff, best_pp1_in;
   logic [DATA_W-1:0] best_rp1_ff, best_rp1_in;
   logic [DATA_W-1:0] best_freq_ff, best_freq_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PRESCALER_W-1:0] rsp_presc_ff, rsp_presc_in;
   logic [RELOAD_W-1:0]    rsp_reload_ff, rsp_reload_in;
   logic [DATA_W-1:0]      rsp_freq_ff, rsp_freq_in;
   logic                   rsp_nofit_ff, rsp_nofit_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                     req_beat;
   logic                     rsp_load;
   logic [P1W+PRESCALER_W-1:0] presc_wide;
   logic [DATA_W-1:0]        reload_wide;

   tdps_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   // output register is free when empty or being drained this cycle
   assign rsp_load   = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               // a zero target cannot fit: report straight away
               state_in = (req_tdata == '0) ? ST_FINISH : ST_IDEAL_GO;
            end
         end
         ST_IDEAL_GO:   state_in = ST_IDEAL_WAIT;
         ST_IDEAL_WAIT: if (div_rsp.done) state_in = ST_RP1_GO;
         ST_RP1_GO:     state_in = ST_RP1_WAIT;
         ST_RP1_WAIT: begin
            if (div_rsp.done) begin
               // a zero reload ratio stays zero for every larger prescaler
               if (div_rsp.quotient == '0)                        state_in = ST_FINISH;
               else if ({1'b0, div_rsp.quotient} > RELOAD_LIMIT)  state_in = ST_NEXT;
               else                                               state_in = ST_MUL;
            end
         end
         ST_MUL:        if (mplier_ff == '0) state_in = ST_FREQ_GO;
         ST_FREQ_GO:    state_in = ST_FREQ_WAIT;
         ST_FREQ_WAIT:  if (div_rsp.done) state_in = ST_ERR;
         ST_ERR:        state_in = ST_CMP;
         ST_CMP:        state_in = (err_ff == '0) ? ST_FINISH : ST_NEXT;
         ST_NEXT: begin
            state_in = (pp1_ff == P1W'(PRESCALER_LIMIT)) ? ST_FINISH : ST_RP1_GO;
         end
         ST_FINISH:     if (rsp_load) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      clk_in       = clk_ff;
      tgt_in       = tgt_ff;
      ideal_in     = ideal_ff;
      pp1_in       = pp1_ff;
      rp1_in       = rp1_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      prod_in      = prod_ff;
      freq_in      = freq_ff;
      err_in       = err_ff;
      found_in     = found_ff;
      best_err_in  = best_err_ff;
      best_pp1_in  = best_pp1_ff;
      best_rp1_in  = best_rp1_ff;
      best_freq_in = best_freq_ff;

      rsp_presc_in  = rsp_presc_ff;
      rsp_reload_in = rsp_reload_ff;
      rsp_freq_in   = rsp_freq_ff;
      rsp_nofit_in  = rsp_nofit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      div_req.start    = 1'b0;
      div_req.dividend = clk_ff;
      div_req.divisor  = tgt_ff;

      presc_wide  = (P1W + PRESCALER_W)'(best_pp1_ff - P1W'(1));
      reload_wide = best_rp1_ff - DATA_W'(1);

      if (csr_valid) begin
         clk_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               tgt_in   = req_tdata;
               found_in = 1'b0;
               pp1_in   = P1W'(1);
            end
         end
         ST_IDEAL_GO: begin
            div_req.start = 1'b1;
         end
         ST_IDEAL_WAIT: begin
            if (div_rsp.done) ideal_in = div_rsp.quotient;
         end
         ST_RP1_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = ideal_ff;
            div_req.divisor  = DATA_W'(pp1_ff);
         end
         ST_RP1_WAIT: begin
            if (div_rsp.done) begin
               rp1_in    = div_rsp.quotient;
               mcand_in  = div_rsp.quotient;
               mplier_in = pp1_ff;
               prod_in   = '0;
            end
         end
         ST_MUL: begin
            // shift-add, one multiplier bit a cycle; the product never exceeds the ratio
            if (mplier_ff != '0) begin
               if (mplier_ff[0]) prod_in = prod_ff + mcand_ff;
               mcand_in  = {mcand_ff[DATA_W-2:0], 1'b0};
               mplier_in = mplier_ff >> 1;
            end
         end
         ST_FREQ_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = clk_ff;
            div_req.divisor  = prod_ff;
         end
         ST_FREQ_WAIT: begin
            if (div_rsp.done) freq_in = div_rsp.quotient;
         end
         ST_ERR: begin
            err_in = (tgt_ff > freq_ff) ? (tgt_ff - freq_ff) : (freq_ff - tgt_ff);
         end
         ST_CMP: begin
            // strictly smaller only, so the lowest prescaler wins a tie
            if (!found_ff || (err_ff < best_err_ff)) begin
               found_in     = 1'b1;
               best_err_in  = err_ff;
               best_pp1_in  = pp1_ff;
               best_rp1_in  = rp1_ff;
               best_freq_in = freq_ff;
            end
         end
         ST_NEXT: begin
            if (pp1_ff != P1W'(PRESCALER_LIMIT)) pp1_in = pp1_ff + P1W'(1);
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_nofit_in = !found_ff;
               if (found_ff) begin
                  rsp_presc_in  = presc_wide[PRESCALER_W-1:0];
                  rsp_reload_in = reload_wide[RELOAD_W-1:0];
                  rsp_freq_in   = best_freq_ff;
               end else begin
                  rsp_presc_in  = '0;
                  rsp_reload_in = '0;
                  rsp_freq_in   = clk_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clk_ff       <= TIMER_CLOCK_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clk_ff       <= clk_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff        <= tgt_in;
      ideal_ff      <= ideal_in;
      pp1_ff        <= pp1_in;
      rp1_ff        <= rp1_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      prod_ff       <= prod_in;
      freq_ff       <= freq_in;
      err_ff        <= err_in;
      found_ff      <= found_in;
      best_err_ff   <= best_err_in;
      best_pp1_ff   <= best_pp1_in;
      best_rp1_ff   <= best_rp1_in;
      best_freq_ff  <= best_freq_in;
      rsp_presc_ff  <= rsp_presc_in;
      rsp_reload_ff <= rsp_reload_in;
      rsp_freq_ff   <= rsp_freq_in;
      rsp_nofit_ff  <= rsp_nofit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_freq_ff, rsp_reload_ff, rsp_presc_ff};
   assign rsp_tuser  = rsp_nofit_ff;

endmodule

// ----- design/tdps_chk.sv -----
`timescale 1ns / 1ps
// Port-level checker for the timer divider pair search, with its bind.
// Depends on tdps_pkg and timer_divider_pair_search_top.
module tdps_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tdps_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser
);
   import tdps_pkg::*;

   // hold a stalled response beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response beat changed");

   // drop any pending result at reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // one search at a time: busy right after taking a request
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a search is running");

   // no fit reports zero prescaler and reload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[PRESCALER_W+RELOAD_W-1:0] == '0)
      else $error("no-fit beat with nonzero divider pair");

   // a fitting pair never divides below one hertz
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[RSP_FIELDS_W-1:PRESCALER_W+RELOAD_W] != '0)
      else $error("fitting pair with zero frequency");

endmodule

bind timer_divider_pair_search_top tdps_chk u_tdps_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- bench/timer_divider_pair_search_checker.sv -----
`timescale 1ns / 1ps
// Checker for the timer divider pair search: watches the csr, req and rsp channels,
// works out the expected divider pair for each target beat and compares every result.
// Depends on tdps_pkg only.
module timer_divider_pair_search_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [tdps_pkg::DATA_W-1:0]      csr_data,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [tdps_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [tdps_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             rsp_tuser,
   output int                               mismatch_count,
   output int                               pairs_outstanding
);
   import tdps_pkg::*;

   typedef struct packed {
      logic                   no_fit;
      logic [DATA_W-1:0]      actual_freq;
      logic [RELOAD_W-1:0]    reload;
      logic [PRESCALER_W-1:0] prescaler;
   } divider_pair_type;

   logic [DATA_W-1:0] timer_clock_hz = TIMER_CLOCK_RESET;
   divider_pair_type  expected_pairs[$];
   divider_pair_type  seen_pair;
   divider_pair_type  want_pair;

   initial mismatch_count = 0;
   initial pairs_outstanding = 0;

   // Walk every prescaler; keep the first pair with the smallest error, stop on exact.
   function automatic divider_pair_type search_divider_pair(
      input logic [DATA_W-1:0] target,
      input logic [DATA_W-1:0] clk_hz);
      logic [63:0]      clk64;
      logic [63:0]      ideal;
      logic [63:0]      rp1;
      logic [63:0]      freq;
      logic [63:0]      err;
      logic [63:0]      best_err;
      logic [63:0]      best_p;
      logic [63:0]      best_r;
      logic [63:0]      div_by;
      bit               found;
      int               p;
      divider_pair_type pair;
      clk64    = {32'd0, clk_hz};
      best_p   = 0;
      best_r   = 0;
      best_err = 0;
      found    = 1'b0;
      if (target != 0) begin
         ideal = clk64 / {32'd0, target};
         for (p = 0; p < PRESCALER_LIMIT_DEF; p++) begin
            div_by = 64'(p) + 64'd1;
            rp1    = ideal / div_by;
            if (rp1 != 0 && rp1 <= {31'd0, RELOAD_LIMIT}) begin
               freq = clk64 / (div_by * rp1);
               err  = ({32'd0, target} > freq) ? ({32'd0, target} - freq)
                                               : (freq - {32'd0, target});
               if (!found || err < best_err) begin
                  found    = 1'b1;
                  best_err = err;
                  best_p   = 64'(p);
                  best_r   = rp1 - 64'd1;
               end
               if (err == 0) break;
            end
         end
      end
      pair.prescaler   = best_p[PRESCALER_W-1:0];
      pair.reload      = best_r[RELOAD_W-1:0];
      pair.actual_freq = 32'(clk64 / ((best_p + 64'd1) * (best_r + 64'd1)));
      pair.no_fit      = !found;
      return pair;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         timer_clock_hz <= TIMER_CLOCK_RESET;
         expected_pairs.delete();
         pairs_outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready)
            timer_clock_hz <= csr_data;
         if (req_tvalid && req_tready)
            expected_pairs.push_back(search_divider_pair(req_tdata[DATA_W-1:0],
                                                         timer_clock_hz));
         if (rsp_tvalid && rsp_tready) begin
            seen_pair.prescaler   = rsp_tdata[PRESCALER_W-1:0];
            seen_pair.reload      = rsp_tdata[PRESCALER_W +: RELOAD_W];
            seen_pair.actual_freq = rsp_tdata[PRESCALER_W + RELOAD_W +: DATA_W];
            seen_pair.no_fit      = rsp_tuser;
            if (expected_pairs.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: result beat with none pending: psc %0d rld %0d f %0d nf %0b",
                           $realtime, seen_pair.prescaler, seen_pair.reload,
                           seen_pair.actual_freq, seen_pair.no_fit);
               mismatch_count++;
            end else begin
               want_pair = expected_pairs.pop_front();
               if (seen_pair.prescaler   != want_pair.prescaler   ||
                   seen_pair.reload      != want_pair.reload      ||
                   seen_pair.actual_freq != want_pair.actual_freq ||
                   seen_pair.no_fit      != want_pair.no_fit) begin
                  if (mismatch_count < 10) begin
                     $write("%0t: mismatch: expected psc %0d rld %0d f %0d nf %0b,",
                            $realtime, want_pair.prescaler, want_pair.reload,
                            want_pair.actual_freq, want_pair.no_fit);
                     $display(" got psc %0d rld %0d f %0d nf %0b",
                              seen_pair.prescaler, seen_pair.reload,
                              seen_pair.actual_freq, seen_pair.no_fit);
                  end
                  mismatch_count++;
               end
            end
         end
         pairs_outstanding <= expected_pairs.size();
      end
   end

endmodule

// ----- bench/timer_divider_pair_search_top_test.sv -----
`timescale 1ns / 1ps
// Test top for the timer divider pair search: clock, reset, stimulus and verdict.
// Depends on tdps_pkg, timer_divider_pair_search_top and timer_divider_pair_search_checker.
module timer_divider_pair_search_top_test;
   import tdps_pkg::*;

   // Quiet cycles allowed before giving up; set well above one full 1024-prescaler
   // search, so this leaves plenty of margin for receiver stalls.
   localparam int QUIET_LIMIT = 400000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [DATA_W-1:0]      csr_data   = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [31:0] target_freq
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [9:0] prescaler, [25:10] reload,
                                              // [57:26] actual_freq
   logic                   rsp_tuser;         // no_fit
   bit                     no_idling  = 1'b0;
   int                     mismatch_count;
   int                     pairs_outstanding;
   int                     quiet_cycles = 0;
   logic [DATA_W-1:0]      phase_clock[4];

   always #5 clock = ~clock;

   timer_divider_pair_search_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   timer_divider_pair_search_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .mismatch_count    (mismatch_count),
      .pairs_outstanding (pairs_outstanding)
   );

   // Receiver: stall with a chance of about 31 percent, except during the steady stretch.
   always @(posedge clock)
      rsp_tready <= no_idling || ($urandom_range(0, 99) >= 31);

   // Watchdog: restart the count on any beat on any channel, give up when it runs out.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // All tasks below start and end in the time step of a rising edge. Readiness is
   // looked at on the falling edge, where it is settled, so the beat lands on the
   // following rising edge without racing the block's own registers.

   // Offer one target beat; idle first at random, then hold valid until taken.
   task automatic send_target(input logic [DATA_W-1:0] target);
      while (!no_idling && $urandom_range(0, 99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= target;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   // Drop valid and hold off until every expected result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pairs_outstanding != 0);
      @(posedge clock);
   endtask

   // Write the timer clock only once the block has gone idle.
   task automatic write_timer_clock(input logic [DATA_W-1:0] hz);
      drain_results();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= hz;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly aim for a small ideal ratio (short searches with random content);
   // otherwise take a fully random target to toggle every bit.
   function automatic logic [DATA_W-1:0] pick_target(input logic [DATA_W-1:0] hz);
      logic [DATA_W-1:0] ratio;
      logic [DATA_W-1:0] hi;
      logic [DATA_W-1:0] lo;
      if ($urandom_range(0, 99) < 30) return $urandom;
      ratio = $urandom_range(1, 96);
      hi    = hz / ratio;
      lo    = hz / (ratio + 1) + 1;
      if (hi == 0) return $urandom_range(1, 8);
      if (lo >= hi) return hi;
      return $urandom_range(hi, lo);
   endfunction

   initial begin
      phase_clock[0] = $urandom;
      phase_clock[1] = $urandom_range(1, 100000);
      phase_clock[2] = 32'hFFFF_FFFF;
      phase_clock[3] = 32'd84000000;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset clock of 84 MHz.
      send_target(32'd1);             // ratio too large for any prescaler: no fit
      send_target(32'hFFFF_FFFF);     // ratio of zero: no fit
      send_target(32'd0);             // target of zero: no fit
      send_target(32'd84000000);      // divide by one, exact
      send_target(32'd1000);          // exact at prescaler 1
      send_target(32'd2000);          // exact at prescaler 0
      send_target(32'd1281);          // first prescaler skipped, reload just too big
      send_target(32'd1282);
      send_target(32'd42000001);      // ratio of one, not exact
      send_target(32'd30000000);      // equal errors at two prescalers: lowest wins
      send_target(32'd50);

      // Reload at its top value.
      write_timer_clock(32'hFFFF_0000);
      send_target(32'd65535);
      send_target(32'd7);

      // Largest clock: prescaler at its top value, and a no-fit search through all.
      write_timer_clock(32'hFFFF_FFFF);
      send_target(32'd64);
      send_target(32'd1);
      send_target(32'hFFFF_FFFF);
      send_target(32'd65537);

      // Smallest nonzero clock.
      write_timer_clock(32'd1);
      send_target(32'd1);
      send_target(32'd2);

      // Clock of zero: nothing fits and the frequency reads back as zero.
      write_timer_clock(32'd0);
      send_target(32'd5);
      send_target(32'd0);

      // Random phases, one clock setting each; the last runs without idling.
      for (int ph = 0; ph < 4; ph++) begin
         write_timer_clock(phase_clock[ph]);
         no_idling <= (ph == 3);
         for (int i = 0; i < 20; i++) begin
            if (i == 10) drain_results();   // let the pipeline run dry mid-phase
            send_target(pick_target(phase_clock[ph]));
         end
      end

      drain_results();
      no_idling <= 1'b0;
      repeat (50) @(posedge clock);

      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
